### rtl/perlin_noise_color_map_top_assert.svh
// Assertion macros for the noise colour map checker.
// Included by the checker file only; no other dependencies.
`ifndef PERLIN_NOISE_COLOR_MAP_TOP_ASSERT_SVH
`define PERLIN_NOISE_COLOR_MAP_TOP_ASSERT_SVH
// Plain implication check under reset.
`define PN_ASSERT_IMP(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");
// Next-cycle implication check under reset.
`define PN_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`endif

### rtl/pncm_pkg.sv
// Shared types, constants and the gradient function of the noise colour map block.
// No dependencies.
package pncm_pkg;
    localparam int unsigned FRAC_BITS = 16;
    localparam logic [16:0] ONE_Q16   = 17'h10000;
    localparam logic [14:0] ONE_Q14   = 15'd16384;

    typedef enum logic {
        ACT_LOAD = 1'b0,
        ACT_EVAL = 1'b1
    } t_action;

    typedef enum logic [1:0] {
        REG_SCALE = 2'd0,
        REG_LOW   = 2'd1,
        REG_MID   = 2'd2,
        REG_HIGH  = 2'd3
    } t_reg_index;

    // Gradient of improved Perlin noise: offsets are signed Q1.16.
    function automatic logic signed [18:0] grad(input logic [3:0] h,
                                                input logic signed [17:0] x,
                                                input logic signed [17:0] y);
        logic signed [18:0] u;
        logic signed [18:0] v;
        u = (h < 4'd8) ? 19'(x) : 19'(y);
        if (h < 4'd4)
            v = 19'(y);
        else if (h == 4'd12 || h == 4'd14)
            v = 19'(x);
        else
            v = '0;
        if (h[0]) u = -u;
        if (h[1]) v = -v;
        return u + v;
    endfunction
endpackage

### rtl/perlin_noise_color_map_top.sv
// Top level of the Perlin noise colour map pipeline.
// Depends on pncm_pkg, pncm_ram, pncm_fade and pncm_lerp.
// Accepts one word per clock while its output is free or taken; each evaluate
// word's result word is presented through a ten-stage pipeline that advances
// whenever its output is free or taken. Load words write the permutation table
// and give no result. The stages hold the two serial table reads (hash of column,
// then of row), the three multiplier stages of the fade and the two lerp levels;
// each of the six table copies serves one read a cycle.
module perlin_noise_color_map_top #(
    parameter int TABLE_ENTRIES = 256,
    parameter int COORD_BITS    = 12
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: table_index[7:0], table_value[15:8], cell_col, cell_row, zero pad
    input  logic [((16 + 2 * COORD_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
    // tuser: action
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: noise_value[15:0], red, green, blue, alpha[47:40]
    output logic [47:0] m_axis_tdata,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_wdata
);
    import pncm_pkg::*;
    localparam int IW = $clog2(TABLE_ENTRIES);
    localparam int NS = 10;

    logic [15:0] r_scale;
    logic [31:0] r_low, r_mid, r_high;
    logic [NS-1:0] r_v;
    logic adv;
    logic [COORD_BITS-1:0] w_col, w_row;

    assign adv = !r_v[NS-1] || m_axis_tready;
    assign s_axis_tready = adv;
    assign w_col = s_axis_tdata[16 +: COORD_BITS];
    assign w_row = s_axis_tdata[16 + COORD_BITS +: COORD_BITS];

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= 16'd5243;
            r_low   <= 32'd7991807;
            r_mid   <= 32'd2137673727;
            r_high  <= 32'd14954751;
        end else if (i_cfg_we) begin
            unique case (t_reg_index'(i_cfg_index))
                REG_SCALE: r_scale <= i_cfg_wdata[15:0];
                REG_LOW:   r_low   <= i_cfg_wdata;
                REG_MID:   r_mid   <= i_cfg_wdata;
                REG_HIGH:  r_high  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // valid pipeline
    logic in_eval, in_load;
    assign in_eval = s_axis_tvalid && s_axis_tuser == ACT_EVAL;
    assign in_load = s_axis_tvalid && adv && s_axis_tuser == ACT_LOAD;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v <= '0;
        else if (adv) r_v <= {r_v[NS-2:0], in_eval};
    end

    // load word carried two stages for the corner copies
    logic [1:0] r_ldv;
    logic [IW-1:0] r_ldi [2];
    logic [7:0] r_ldd [2];
    logic w_we_late;
    logic [IW-1:0] w_waddr;
    assign w_waddr = IW'(s_axis_tdata[7:0]);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ldv <= '0;
        else if (adv) r_ldv <= {r_ldv[0], in_load};
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_ldi[0] <= w_waddr;
            r_ldd[0] <= s_axis_tdata[15:8];
            r_ldi[1] <= r_ldi[0];
            r_ldd[1] <= r_ldd[0];
        end
    end
    assign w_we_late = r_ldv[1] && adv;

    // stage 1: coordinate products
    logic [COORD_BITS+15:0] r1_cx, r1_cy;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_cx <= (COORD_BITS+16)'(w_col) * (COORD_BITS+16)'(r_scale);
            r1_cy <= (COORD_BITS+16)'(w_row) * (COORD_BITS+16)'(r_scale);
        end
    end
    logic [IW-1:0] w1_x, w1_y;
    logic [15:0] w1_fx, w1_fy;
    assign w1_x  = IW'(r1_cx >> 16);
    assign w1_y  = IW'(r1_cy >> 16);
    assign w1_fx = r1_cx[15:0];
    assign w1_fy = r1_cy[15:0];

    // table copies: 0 and 1 read X and X+1, 2 and 3 read A+1 and B+1
    logic [IW-1:0] w_ra [4];
    logic [7:0] w_rd [4];
    genvar g;
    for (g = 0; g < 4; g++) begin : g_tab
        pncm_ram #(.WIDTH(8), .DEPTH(TABLE_ENTRIES)) u_ram (
            .i_clk(i_clk), .i_we((g < 2) ? in_load : w_we_late),
            .i_waddr((g < 2) ? w_waddr : r_ldi[1]),
            .i_wdata((g < 2) ? s_axis_tdata[15:8] : r_ldd[1]), .i_re(adv),
            .i_raddr(w_ra[g]), .o_rdata(w_rd[g]));
    end

    // stage 2: carry Y and fractions while X, X+1 are read
    logic [IW-1:0] r2_y;
    logic [15:0] r_fx [2:4], r_fy [2:4];
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r2_y <= w1_y;
            r_fx[2] <= w1_fx; r_fy[2] <= w1_fy;
            r_fx[3] <= r_fx[2]; r_fy[3] <= r_fy[2];
            r_fx[4] <= r_fx[3]; r_fy[4] <= r_fy[3];
        end
    end
    // stage 3: hash sums A and B registered
    logic [IW-1:0] r3_a, r3_b;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r3_a <= IW'(w_rd[0]) + r2_y;
            r3_b <= IW'(w_rd[1]) + r2_y;
        end
    end
    // corners are read two stages after the X step, so the corner copies
    // take each load two stages late: words ahead still see the old entry
    // and words behind see the new one. A and B come from their own copies.
    logic [7:0] w_rc [4];
    logic [IW-1:0] w_ca [4];
    assign w_ca[0] = r3_a;
    assign w_ca[1] = r3_b;
    assign w_ca[2] = IW'(r3_a + 1'b1);
    assign w_ca[3] = IW'(r3_b + 1'b1);
    assign w_ra[0] = w1_x;
    assign w_ra[1] = IW'(w1_x + 1'b1);
    assign w_ra[2] = w_ca[2];
    assign w_ra[3] = w_ca[3];
    for (g = 0; g < 2; g++) begin : g_tab2
        pncm_ram #(.WIDTH(8), .DEPTH(TABLE_ENTRIES)) u_ram (
            .i_clk(i_clk), .i_we(w_we_late), .i_waddr(r_ldi[1]),
            .i_wdata(r_ldd[1]), .i_re(adv),
            .i_raddr(w_ca[g]), .o_rdata(w_rc[g]));
    end
    assign w_rc[2] = w_rd[2];
    assign w_rc[3] = w_rd[3];

    // fades started at stage 4 input (fractions of stage 3), ready at stage 6
    logic [16:0] w_u, w_vv;
    pncm_fade u_fx (.i_clk(i_clk), .i_en(adv), .i_f(r_fx[3]), .o_fade(w_u));
    pncm_fade u_fy (.i_clk(i_clk), .i_en(adv), .i_f(r_fy[3]), .o_fade(w_vv));

    // stage 5: gradients
    logic signed [17:0] w_x0, w_y0, w_x1, w_y1;
    assign w_x0 = $signed({2'b00, r_fx[4]});
    assign w_y0 = $signed({2'b00, r_fy[4]});
    assign w_x1 = w_x0 - $signed({1'b0, ONE_Q16});
    assign w_y1 = w_y0 - $signed({1'b0, ONE_Q16});
    logic signed [19:0] r5_g [4];
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r5_g[0] <= 20'(grad(w_rc[0][3:0], w_x0, w_y0));
            r5_g[1] <= 20'(grad(w_rc[1][3:0], w_x1, w_y0));
            r5_g[2] <= 20'(grad(w_rc[2][3:0], w_x0, w_y1));
            r5_g[3] <= 20'(grad(w_rc[3][3:0], w_x1, w_y1));
        end
    end
    // v delayed one stage to meet the second lerp
    logic [16:0] r_v7;
    always_ff @(posedge i_clk) if (adv) r_v7 <= w_vv;

    // stage 7: x lerps, stage 8: y lerp
    logic signed [19:0] w_l0, w_l1, w_n;
    logic signed [19:0] r6_g [4];
    always_ff @(posedge i_clk) if (adv) r6_g <= r5_g;
    pncm_lerp u_l0 (.i_clk(i_clk), .i_en(adv), .i_t(w_u), .i_a(r6_g[0]),
                    .i_b(r6_g[1]), .o_y(w_l0));
    pncm_lerp u_l1 (.i_clk(i_clk), .i_en(adv), .i_t(w_u), .i_a(r6_g[2]),
                    .i_b(r6_g[3]), .o_y(w_l1));
    pncm_lerp u_l2 (.i_clk(i_clk), .i_en(adv), .i_t(r_v7), .i_a(w_l0),
                    .i_b(w_l1), .o_y(w_n));

    // stage 9: quantise, saturate, pick colours and factor
    logic signed [17:0] w_q;
    logic signed [15:0] w_qs;
    logic signed [16:0] w_k;
    logic [14:0] r9_k;
    logic signed [15:0] r9_q;
    logic [31:0] r9_c0, r9_c1;
    assign w_q  = 18'(w_n >>> 2);
    assign w_qs = (w_q > 18'sd32767) ? 16'sh7fff :
                  (w_q < -18'sd32768) ? 16'sh8000 : 16'(w_q);
    assign w_k  = w_qs[15] ? 17'(w_qs) + 17'sd16384 : 17'(w_qs);
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r9_q  <= w_qs;
            r9_c0 <= w_qs[15] ? r_low : r_mid;
            r9_c1 <= w_qs[15] ? r_mid : r_high;
            r9_k  <= (w_k < 0) ? 15'd0 : (w_k > 17'sd16384) ? ONE_Q14 : 15'(w_k);
        end
    end

    // stage 10: byte blends into the output register
    logic [7:0] w_byte [4];
    logic [22:0] w_mix [4];
    for (g = 0; g < 4; g++) begin : g_mix
        assign w_mix[g] = 23'(ONE_Q14 - r9_k) * 23'(r9_c0[8*g +: 8])
                        + 23'(r9_k) * 23'(r9_c1[8*g +: 8]);
        assign w_byte[g] = w_mix[g][21:14];
    end
    logic [47:0] r_out;
    always_ff @(posedge i_clk) begin
        if (adv) r_out <= {w_byte[0], w_byte[1], w_byte[2], w_byte[3], r9_q};
    end
    assign m_axis_tvalid = r_v[NS-1];
    assign m_axis_tdata  = r_out;
endmodule

### rtl/pncm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pncm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        if (i_re) r_rdata <= r_mem[i_raddr];
    end
    assign o_rdata = r_rdata;
endmodule

### rtl/pncm_fade.sv
// Three-stage quintic fade 6t^5-15t^4+10t^3 on a Q0.16 fraction.
// Depends on pncm_pkg.
module pncm_fade (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [15:0] i_f,
    output logic [16:0] o_fade
);
    import pncm_pkg::*;
    logic [15:0] r_f1, r_a1;
    logic [15:0] r_b2;
    logic [19:0] r_p2;
    logic [16:0] r_fade;
    logic [31:0] w_ff, w_af;
    logic [39:0] w_bp;

    assign w_ff = 32'(i_f) * 32'(i_f);
    assign w_af = 32'(r_a1) * 32'(r_f1);
    assign w_bp = 40'(r_b2) * 40'(r_p2);

    // a = f^2, then b = a*f and the polynomial, then b*p
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_f1   <= i_f;
            r_a1   <= w_ff[31:16];
            r_b2   <= w_af[31:16];
            r_p2   <= 20'(20'd6 * 20'(r_a1) + 20'd655360 - 20'd15 * 20'(r_f1));
            r_fade <= w_bp[32:16];
        end
    end
    assign o_fade = r_fade;
endmodule

### rtl/pncm_lerp.sv
// One registered lerp stage: a + floor((b-a)*t / 2^16).
// Depends on pncm_pkg.
module pncm_lerp (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic        [16:0] i_t,
    input  logic signed [19:0] i_a,
    input  logic signed [19:0] i_b,
    output logic signed [19:0] o_y
);
    import pncm_pkg::*;
    logic signed [20:0] w_d;
    logic signed [38:0] w_m;
    logic signed [19:0] r_y;

    assign w_d = 21'(i_b) - 21'(i_a);
    assign w_m = 39'(w_d) * $signed({22'd0, i_t});

    // arithmetic shift floors
    always_ff @(posedge i_clk) begin
        if (i_en) r_y <= 20'(21'(i_a) + 21'(w_m >>> FRAC_BITS));
    end
    assign o_y = r_y;
endmodule

### rtl/pncm_checker.sv
// Port-level checker for the noise colour map, bound to the top level.
// Depends on pncm_pkg and perlin_noise_color_map_top_assert.svh.
`include "perlin_noise_color_map_top_assert.svh"
module pncm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata
);
    import pncm_pkg::*;
    // a stalled result holds its value
    `PN_ASSERT_NEXT(a_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
    // input is free whenever the output is free
    `PN_ASSERT_IMP(a_ready, i_clk, i_rst_n, !m_axis_tvalid, s_axis_tready)
    // a stalled result stays offered
    `PN_ASSERT_NEXT(a_keep, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
endmodule

bind perlin_noise_color_map_top pncm_checker u_chk (.*);

### bench/tb_perlin_noise_color_map_top.sv
// Self-checking bench for the Perlin noise colour map top level.
// Depends on pncm_pkg and perlin_noise_color_map_top; a scoreboard class predicts results.
module tb_perlin_noise_color_map_top;
    import pncm_pkg::*;

    localparam int COORD = 12;
    localparam int DW = ((16 + 2 * COORD + 7) / 8) * 8;
    localparam int WD_LIMIT = 5000;

    // Expected result word
    typedef struct packed {
        logic [7:0]         alpha;
        logic [7:0]         blue;
        logic [7:0]         green;
        logic [7:0]         red;
        logic signed [15:0] noise;
    } t_pixel;

    // Noise predictor and queue of pending pixels
    class pixel_board;
        logic [15:0] scale;
        logic [31:0] col_lo, col_mid, col_hi;
        logic [7:0]  perm [256];
        t_pixel      pending [$];
        int          errors;

        function void reset_state();
            scale = 16'd5243; col_lo = 32'd7991807;
            col_mid = 32'd2137673727; col_hi = 32'd14954751;
            foreach (perm[i]) perm[i] = '0;
            errors = 0;
        endfunction

        function void set_reg(t_reg_index idx, logic [31:0] v);
            case (idx)
                REG_SCALE: scale = v[15:0];
                REG_LOW:   col_lo = v;
                REG_MID:   col_mid = v;
                REG_HIGH:  col_hi = v;
            endcase
        endfunction

        function longint fl_shift(longint v, int s);
            return v >>> s;   // arithmetic shift floors
        endfunction

        function longint fade(longint f);
            longint a, b, p;
            a = (f * f) >> 16;
            b = (a * f) >> 16;
            p = 6 * a + 655360 - 15 * f;
            return (b * p) >> 16;
        endfunction

        function longint gradv(logic [7:0] hash, longint x, longint y);
            logic [3:0] h;
            longint u, v;
            h = hash[3:0];
            u = (h < 8) ? x : y;
            v = (h < 4) ? y : ((h == 12 || h == 14) ? x : 0);
            return (h[0] ? -u : u) + (h[1] ? -v : v);
        endfunction

        function longint mix(longint t, longint a, longint b);
            return a + fl_shift((b - a) * t, 16);
        endfunction

        function logic [7:0] mixb(logic [7:0] b0, logic [7:0] b1, longint k);
            longint r;
            r = ((16384 - k) * b0 + k * b1) >> 14;
            return r[7:0];
        endfunction

        // Note an accepted input word
        function void note_input(t_action act, logic [7:0] idx, logic [7:0] val,
                                 logic [11:0] col, logic [11:0] row);
            longint cx, cy, fx, fy, u, v, x1, y1, n, q, k;
            logic [7:0] xi, yi, ai, bi;
            logic [31:0] c0, c1;
            t_pixel px;
            if (act == ACT_LOAD) begin
                perm[idx] = val;
                return;
            end
            cx = longint'(col) * scale;
            cy = longint'(row) * scale;
            xi = cx[23:16]; yi = cy[23:16];
            fx = cx & 16'hFFFF; fy = cy & 16'hFFFF;
            u = fade(fx); v = fade(fy);
            x1 = fx - 65536; y1 = fy - 65536;
            ai = perm[xi] + yi;
            bi = perm[8'(xi + 1)] + yi;
            n = mix(v, mix(u, gradv(perm[ai], fx, fy), gradv(perm[bi], x1, fy)),
                       mix(u, gradv(perm[8'(ai + 1)], fx, y1),
                           gradv(perm[8'(bi + 1)], x1, y1)));
            q = fl_shift(n, 2);
            if (q > 32767) q = 32767;
            if (q < -32768) q = -32768;
            if (q < 0) begin
                k = q + 16384; c0 = col_lo; c1 = col_mid;
            end else begin
                k = q; c0 = col_mid; c1 = col_hi;
            end
            if (k < 0) k = 0;
            if (k > 16384) k = 16384;
            px.noise = q[15:0];
            px.red   = mixb(c0[31:24], c1[31:24], k);
            px.green = mixb(c0[23:16], c1[23:16], k);
            px.blue  = mixb(c0[15:8], c1[15:8], k);
            px.alpha = mixb(c0[7:0], c1[7:0], k);
            pending = {pending, px};
        endfunction

        // Compare a received word with the oldest pending pixel
        function void check_result(logic [47:0] d);
            t_pixel e, a;
            a = d;
            if (pending.size() == 0) begin
                $error("unexpected result word %h", d);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (a.noise !== e.noise) begin
                $error("noise_value exp %0d got %0d", e.noise, a.noise); errors++;
            end
            if (a.red !== e.red) begin
                $error("red exp %0d got %0d", e.red, a.red); errors++;
            end
            if (a.green !== e.green) begin
                $error("green exp %0d got %0d", e.green, a.green); errors++;
            end
            if (a.blue !== e.blue) begin
                $error("blue exp %0d got %0d", e.blue, a.blue); errors++;
            end
            if (a.alpha !== e.alpha) begin
                $error("alpha exp %0d got %0d", e.alpha, a.alpha); errors++;
            end
        endfunction
    endclass

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          s_axis_tvalid = 1'b0;
    logic          s_axis_tready;
    logic [DW-1:0] s_axis_tdata = '0;
    logic          s_axis_tuser = 1'b0;
    logic          m_axis_tvalid;
    logic          m_axis_tready = 1'b0;
    logic [47:0]   m_axis_tdata;
    logic          i_cfg_we = 1'b0;
    logic [1:0]    i_cfg_index = '0;
    logic [31:0]   i_cfg_wdata = '0;

    pixel_board board = new();
    int  send_idle = 0;   // percent of cycles the sender idles
    int  recv_idle = 0;
    int  quiet_cycles = 0;

    perlin_noise_color_map_top dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Receiver stall, output check and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata);
            if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WD_LIMIT) begin
                $display("perlin_noise_color_map_top: mismatch");
                $finish;
            end
        end
        m_axis_tready <= ($urandom_range(99) >= recv_idle);
    end

    // Send one word, idling at random first; valid is dropped by the next
    // idle cycle or by drain
    task automatic send_word(t_action act, logic [7:0] idx, logic [7:0] val,
                             logic [11:0] col, logic [11:0] row);
        while ($urandom_range(99) < send_idle) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= DW'({row, col, val, idx});
        do @(posedge i_clk); while (!s_axis_tready);
        board.note_input(act, idx, val, col, row);
    endtask

    // Wait until every pending pixel has arrived, plus pipeline slack
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(t_reg_index idx, logic [31:0] v);
        i_cfg_we <= 1'b1; i_cfg_index <= idx; i_cfg_wdata <= v;
        @(posedge i_clk);
        board.set_reg(idx, v);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Fill the whole permutation table with a random or reversed pattern
    task automatic load_table(bit shuffled);
        for (int i = 0; i < 256; i++)
            send_word(ACT_LOAD, 8'(i), shuffled ? 8'($urandom) : 8'(255 - i),
                      12'($urandom), 12'($urandom));
    endtask

    task automatic eval_rand(int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(19) == 0)
                send_word(ACT_LOAD, 8'($urandom), 8'($urandom),
                          12'($urandom), 12'($urandom));
            else
                send_word(ACT_EVAL, 8'($urandom), 8'($urandom),
                          ($urandom_range(9) == 0) ? 12'hFFF : 12'($urandom),
                          ($urandom_range(9) == 0) ? 12'h000 : 12'($urandom));
        end
    endtask

    initial begin
        board.reset_state();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: full table, then corners and register extremes
        load_table(1'b0);
        send_word(ACT_EVAL, 8'hFF, 8'h00, 12'd0, 12'd0);
        send_word(ACT_EVAL, 8'h00, 8'hFF, 12'hFFF, 12'hFFF);
        send_word(ACT_EVAL, 8'h5A, 8'hA5, 12'd1, 12'hFFF);
        send_word(ACT_EVAL, 8'hA5, 8'h5A, 12'hFFF, 12'd1);
        send_word(ACT_EVAL, 8'h00, 8'h00, 12'd7, 12'd13);
        drain();
        write_reg(REG_SCALE, 32'hFFFF);
        write_reg(REG_LOW, 32'h0000_0000);
        write_reg(REG_MID, 32'hFFFF_FFFF);
        write_reg(REG_HIGH, 32'h0000_0000);
        send_word(ACT_EVAL, 8'h00, 8'h00, 12'hFFF, 12'hFFF);
        send_word(ACT_EVAL, 8'h00, 8'h00, 12'd3, 12'd2049);
        send_word(ACT_EVAL, 8'h00, 8'h00, 12'd2730, 12'd1365);
        drain();
        write_reg(REG_SCALE, 32'h0000);
        send_word(ACT_EVAL, 8'h00, 8'h00, 12'hABC, 12'h123);
        drain();

        // Random phases over idling modes and settings
        load_table(1'b1);
        drain();
        for (int ph = 0; ph < 4; ph++) begin
            write_reg(REG_SCALE, (ph == 3) ? 32'h0001 : $urandom);
            write_reg(REG_LOW, $urandom);
            write_reg(REG_MID, $urandom);
            write_reg(REG_HIGH, $urandom);
            case (ph)
                0: begin send_idle = 0;  recv_idle = 0;  end
                1: begin send_idle = 83; recv_idle = 0;  end
                2: begin send_idle = 0;  recv_idle = 83; end
                default: begin send_idle = 21; recv_idle = 21; end
            endcase
            eval_rand(14);
            drain();   // sender holds off until all pixels are back
            eval_rand(13);
            drain();
        end
        send_idle = 0;
        recv_idle = 0;
        eval_rand(20);
        drain();

        if (board.errors == 0)
            $display("perlin_noise_color_map_top: match");
        else
            $display("perlin_noise_color_map_top: mismatch");
        $finish;
    end
endmodule

### sim.f
+incdir+rtl
rtl/pncm_pkg.sv
rtl/pncm_ram.sv
rtl/pncm_fade.sv
rtl/pncm_lerp.sv
rtl/perlin_noise_color_map_top.sv
rtl/pncm_checker.sv
bench/tb_perlin_noise_color_map_top.sv
